// ===== hdl/i2cm_pkg.sv =====
// Shared types and constants for the I2C master bit engine.
// No dependencies; imported by every module of the block.
`default_nettype none

package i2cm_pkg;

  // Raw input item as it arrives on the tick channel
  typedef struct packed {
    logic [2:0] func;
    logic [7:0] wdata;
    logic       sda_in;
  } in_item_t;

  // One result per tick: line levels and status after the tick
  typedef struct packed {
    logic       scl_out;
    logic       sda_release;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rdata;
    logic       ack_ok;
  } out_item_t;

  // Function codes of the input channel
  localparam logic [2:0] FUNC_TICK  = 3'd0;
  localparam logic [2:0] FUNC_START = 3'd1;
  localparam logic [2:0] FUNC_STOP  = 3'd2;
  localparam logic [2:0] FUNC_WRITE = 3'd3;
  localparam logic [2:0] FUNC_READ  = 3'd4;

  // Classified command carried through the queue
  typedef enum logic [2:0] {
    CMD_TICK  = 3'd0,
    CMD_START = 3'd1,
    CMD_STOP  = 3'd2,
    CMD_WRITE = 3'd3,
    CMD_READ  = 3'd4
  } cmd_t;

  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] wdata;
    logic       sda_in;
  } q_item_t;

  // Configuration register indexes
  localparam logic CFG_HALF_PERIOD = 1'b0;
  localparam logic CFG_ACK_TIMEOUT = 1'b1;

  localparam logic [15:0] HALF_PERIOD_RST = 16'd5;
  localparam logic [15:0] ACK_TIMEOUT_RST = 16'd0;
  localparam int unsigned BYTE_BITS = 8;

endpackage

`default_nettype wire

// ===== hdl/i2cm_front.sv =====
// Front end: accepts ticks, classifies the function code, holds a
// two-entry queue toward the back end. Depends on i2cm_pkg.
`default_nettype none

module i2cm_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire i2cm_pkg::in_item_t in_data,
  output logic                    q_valid,
  input  wire logic               q_pop,
  output i2cm_pkg::q_item_t       q_item
);
  import i2cm_pkg::*;

  q_item_t    entry_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       push;
  logic       pop;
  q_item_t    classified;

  // Map function codes; unused codes act as a plain tick
  always_comb begin
    classified.wdata  = in_data.wdata;
    classified.sda_in = in_data.sda_in;
    case (in_data.func)
      FUNC_START: classified.cmd = CMD_START;
      FUNC_STOP:  classified.cmd = CMD_STOP;
      FUNC_WRITE: classified.cmd = CMD_WRITE;
      FUNC_READ:  classified.cmd = CMD_READ;
      default:    classified.cmd = CMD_TICK;
    endcase
  end

  assign in_stall = (count_r == 2'd2);
  assign q_valid  = (count_r != 2'd0);
  assign q_item   = entry_r[rd_ptr_r];
  assign push     = in_valid & ~in_stall;
  assign pop      = q_pop & q_valid;

  // Pointer and occupancy update
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (!push && pop) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Queue storage, no reset needed
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= classified;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/i2cm_back.sv =====
// Back end: bus sequencer that runs one queued tick per cycle unless the
// result is stalled, and registers it. Holds the config registers. Depends on i2cm_pkg.
`default_nettype none

module i2cm_back #(
  parameter int COUNT_WIDTH = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_valid,
  input  wire logic               cfg_index,
  input  wire logic [15:0]        cfg_wdata,
  input  wire logic               q_valid,
  output logic                    q_pop,
  input  wire i2cm_pkg::q_item_t  q_item,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output i2cm_pkg::out_item_t     out_data
);
  import i2cm_pkg::*;

  localparam int LW = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_ST_A   = 4'd1,
    PH_ST_B   = 4'd2,
    PH_SP_A   = 4'd3,
    PH_SP_B   = 4'd4,
    PH_W_LOW  = 4'd5,
    PH_W_HIGH = 4'd6,
    PH_A_LOW  = 4'd7,
    PH_A_WAIT = 4'd8,
    PH_A_END  = 4'd9,
    PH_R_LOW  = 4'd10,
    PH_R_HIGH = 4'd11,
    PH_N_LOW  = 4'd12,
    PH_N_HIGH = 4'd13
  } phase_t;

  logic [15:0]            half_period_r;
  logic [15:0]            ack_timeout_r;
  phase_t                 phase_r, phase_nxt;
  logic [3:0]             bit_r, bit_nxt;
  logic [7:0]             shift_r, shift_nxt;
  logic [COUNT_WIDTH-1:0] tick_r, tick_nxt, tick_inc;
  logic                   scl_r, scl_nxt;
  logic                   sda_r, sda_nxt;
  logic                   ack_r, ack_nxt;
  logic [7:0]             rdata_r, rdata_nxt;
  logic                   done;
  logic                   out_valid_r;
  out_item_t              out_r;
  logic                   take;
  logic [LW-1:0]          hp_w, to_w, max_w, lim_w, tlim_w;
  logic [COUNT_WIDTH-1:0] limit, to_limit;
  logic [3:0]             bit_inc;
  logic [7:0]             shift_w, shift_r_in;

  // Limits clamped to what the tick counter can hold
  always_comb begin
    hp_w     = LW'((half_period_r == 16'd0) ? 16'd1 : half_period_r);
    to_w     = LW'(ack_timeout_r);
    max_w    = LW'(CNT_MAX);
    lim_w    = (hp_w > max_w) ? max_w : hp_w;
    tlim_w   = (to_w > max_w) ? max_w : to_w;
    limit    = COUNT_WIDTH'(lim_w);
    to_limit = COUNT_WIDTH'(tlim_w);
  end

  assign take       = q_valid & (~out_valid_r | ~out_stall);
  assign q_pop      = take;
  assign tick_inc   = (tick_r == CNT_MAX) ? tick_r : tick_r + 1'b1;
  assign bit_inc    = bit_r + 4'd1;
  assign shift_w    = {shift_r[6:0], 1'b0};
  assign shift_r_in = {shift_r[6:0], q_item.sda_in};

  // Sequencer step for one tick
  always_comb begin
    phase_nxt = phase_r;
    bit_nxt   = bit_r;
    shift_nxt = shift_r;
    tick_nxt  = tick_r;
    scl_nxt   = scl_r;
    sda_nxt   = sda_r;
    ack_nxt   = ack_r;
    rdata_nxt = rdata_r;
    done      = 1'b0;
    if (phase_r == PH_IDLE) begin
      // Command decode while idle
      case (q_item.cmd)
        CMD_START: begin
          phase_nxt = PH_ST_A; scl_nxt = 1'b1; sda_nxt = 1'b1; tick_nxt = '0;
        end
        CMD_STOP: begin
          phase_nxt = PH_SP_A; scl_nxt = 1'b0; sda_nxt = 1'b0; tick_nxt = '0;
        end
        CMD_WRITE: begin
          shift_nxt = q_item.wdata; bit_nxt = 4'd0;
          phase_nxt = PH_W_LOW; scl_nxt = 1'b0; sda_nxt = q_item.wdata[7];
          tick_nxt  = '0;
        end
        CMD_READ: begin
          shift_nxt = 8'd0; bit_nxt = 4'd0;
          phase_nxt = PH_R_LOW; scl_nxt = 1'b0; sda_nxt = 1'b1; tick_nxt = '0;
        end
        default: ;
      endcase
    end else if (phase_r == PH_A_WAIT) begin
      // Acknowledge wait with optional timeout
      if (!q_item.sda_in) begin
        ack_nxt = 1'b1;
        phase_nxt = PH_A_END; scl_nxt = 1'b0; sda_nxt = 1'b1; tick_nxt = '0;
      end else begin
        tick_nxt = tick_inc;
        if (ack_timeout_r != 16'd0 && tick_inc >= to_limit) begin
          ack_nxt = 1'b0;
          phase_nxt = PH_A_END; scl_nxt = 1'b0; sda_nxt = 1'b1; tick_nxt = '0;
        end
      end
    end else begin
      // Timed half-period phases
      tick_nxt = tick_inc;
      if (tick_inc >= limit) begin
        tick_nxt = '0;
        case (phase_r)
          PH_ST_A: begin phase_nxt = PH_ST_B; scl_nxt = 1'b1; sda_nxt = 1'b0; end
          PH_ST_B: begin
            phase_nxt = PH_IDLE; scl_nxt = 1'b0; sda_nxt = 1'b0; done = 1'b1;
          end
          PH_SP_A: begin phase_nxt = PH_SP_B; scl_nxt = 1'b1; sda_nxt = 1'b0; end
          PH_SP_B: begin
            phase_nxt = PH_IDLE; scl_nxt = 1'b1; sda_nxt = 1'b1; done = 1'b1;
          end
          PH_W_LOW: begin phase_nxt = PH_W_HIGH; scl_nxt = 1'b1; end
          PH_W_HIGH: begin
            shift_nxt = shift_w;
            bit_nxt   = bit_inc;
            scl_nxt   = 1'b0;
            if (bit_inc >= 4'(BYTE_BITS)) begin
              phase_nxt = PH_A_LOW; sda_nxt = 1'b1;
            end else begin
              phase_nxt = PH_W_LOW; sda_nxt = shift_w[7];
            end
          end
          PH_A_LOW: begin phase_nxt = PH_A_WAIT; scl_nxt = 1'b1; sda_nxt = 1'b1; end
          PH_A_END: begin
            phase_nxt = PH_IDLE; scl_nxt = 1'b0; sda_nxt = 1'b1; done = 1'b1;
          end
          PH_R_LOW: begin phase_nxt = PH_R_HIGH; scl_nxt = 1'b1; sda_nxt = 1'b1; end
          PH_R_HIGH: begin
            // Sample at the end of SCL high
            shift_nxt = shift_r_in;
            bit_nxt   = bit_inc;
            scl_nxt   = 1'b0;
            sda_nxt   = 1'b1;
            phase_nxt = (bit_inc >= 4'(BYTE_BITS)) ? PH_N_LOW : PH_R_LOW;
          end
          PH_N_LOW: begin phase_nxt = PH_N_HIGH; scl_nxt = 1'b1; sda_nxt = 1'b1; end
          PH_N_HIGH: begin
            rdata_nxt = shift_r;
            phase_nxt = PH_IDLE; scl_nxt = 1'b0; sda_nxt = 1'b1; done = 1'b1;
          end
          default: phase_nxt = PH_IDLE;
        endcase
      end
    end
  end

  // State, config and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_period_r <= HALF_PERIOD_RST;
      ack_timeout_r <= ACK_TIMEOUT_RST;
      phase_r       <= PH_IDLE;
      bit_r         <= 4'd0;
      shift_r       <= 8'd0;
      tick_r        <= '0;
      scl_r         <= 1'b1;
      sda_r         <= 1'b1;
      ack_r         <= 1'b0;
      rdata_r       <= 8'd0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_HALF_PERIOD: half_period_r <= cfg_wdata;
          CFG_ACK_TIMEOUT: ack_timeout_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (take) begin
        phase_r <= phase_nxt;
        bit_r   <= bit_nxt;
        shift_r <= shift_nxt;
        tick_r  <= tick_nxt;
        scl_r   <= scl_nxt;
        sda_r   <= sda_nxt;
        ack_r   <= ack_nxt;
        rdata_r <= rdata_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_r.scl_out     <= scl_nxt;
      out_r.sda_release <= sda_nxt;
      out_r.busy_res    <= (phase_nxt != PH_IDLE);
      out_r.done_res    <= done;
      out_r.rdata       <= rdata_nxt;
      out_r.ack_ok      <= ack_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

// ===== hdl/i2c_master_bit_engine.sv =====
// Top level of the I2C master bit engine: front queue plus sequencer.
// Depends on i2cm_pkg, i2cm_front and i2cm_back.
//
//  Channel   Handshake           Payload
//  in_       in_valid/in_stall   in_item_t  {func, wdata, sda_in}
//  out_      out_valid/out_stall out_item_t {scl_out, sda_release, busy_res,
//                                            done_res, rdata, ack_ok}
//  cfg_      cfg_valid/cfg_ready cfg_index (1 bit), cfg_wdata (16 bit)
//
// One tick per clock cycle sustained while the result side does not stall;
// each tick passes through a queue entry, then the result register.
// The two-entry queue lets ticks keep arriving after the result side
// stalls; in_stall rises only when the queue is full.
// Synchronous active-low reset empties the queue and sets the bus idle,
// both lines released; config registers return to half period 5, timeout 0.
`default_nettype none

module i2c_master_bit_engine #(
  parameter int COUNT_WIDTH = 16
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire i2cm_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output i2cm_pkg::out_item_t      out_data,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic                cfg_index,
  input  wire logic [15:0]         cfg_wdata
);
  import i2cm_pkg::*;

  logic    q_valid;
  logic    q_pop;
  q_item_t q_item;

  assign cfg_ready = 1'b1;

  i2cm_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_item   (q_item)
  );

  i2cm_back #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid & cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_item    (q_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // A finishing tick always leaves the engine idle
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.done_res |-> !out_data.busy_res)
    else $error("done pulse while still busy");

  // The queue only fills behind a held result
  a_full_backlog: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with no pending result");

  // A stop completion leaves both lines released
  a_stop_release: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.done_res && out_data.scl_out |-> out_data.sda_release)
    else $error("stop finished with SDA held low");

  // Nothing leaves reset as a result
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("channel busy right after reset");

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for the I2C master bit engine (i2c_master_bit_engine).
// Needs i2cm_pkg for the payload types, function codes and register indexes.
// Cycle-level predictor, directed table first, then randomized phases per config.
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import i2cm_pkg::*;

  localparam int COUNT_WIDTH = 16;
  localparam int unsigned CNT_MAX = 32'((64'd1 << COUNT_WIDTH) - 64'd1);
  localparam int WATCHDOG_LIMIT = 1000;

  // func codes above READ are spare and must act as a plain tick
  localparam logic [2:0] FUNC_SPARE_LO = FUNC_READ + 3'd1;
  localparam logic [2:0] FUNC_SPARE_HI = 3'd7;

  // Pacing modes for both sides
  localparam int PACE_NONE  = 0;
  localparam int PACE_FULL  = 1;
  localparam int PACE_SPARSE = 2;

  // Sequencer phases, in the engine's encoding
  typedef enum logic [3:0] {
    PH_IDLE, PH_ST_A, PH_ST_B, PH_SP_A, PH_SP_B, PH_W_LOW, PH_W_HIGH,
    PH_A_LOW, PH_A_WAIT, PH_A_END, PH_R_LOW, PH_R_HIGH, PH_N_LOW, PH_N_HIGH
  } bus_phase_t;

  typedef struct packed {
    in_item_t  tick;
    logic      typed;
    out_item_t res;
  } dir_row_t;

  // Results that can be read straight off the spec
  localparam out_item_t RES_IDLE_RESET = '{scl_out: 1'b1, sda_release: 1'b1,
    busy_res: 1'b0, done_res: 1'b0, rdata: 8'h00, ack_ok: 1'b0};
  localparam out_item_t RES_START_OPEN = '{scl_out: 1'b1, sda_release: 1'b1,
    busy_res: 1'b1, done_res: 1'b0, rdata: 8'h00, ack_ok: 1'b0};
  localparam out_item_t RES_WRITE_MSB1 = '{scl_out: 1'b0, sda_release: 1'b1,
    busy_res: 1'b1, done_res: 1'b0, rdata: 8'h00, ack_ok: 1'b0};

  logic         clk;
  logic         rst_n;
  logic         in_valid;
  logic         in_stall;
  in_item_t     in_data;
  logic         out_valid;
  logic         out_stall;
  out_item_t    out_data;
  logic         cfg_valid;
  logic         cfg_ready;
  logic         cfg_index;
  logic [15:0]  cfg_wdata;

  i2c_master_bit_engine #(.COUNT_WIDTH(COUNT_WIDTH)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Predicted bus state and config copy
  bus_phase_t   bus_phase;
  logic [3:0]   bit_cnt;
  logic [7:0]   shift_reg;
  int unsigned  hold_count;
  logic         scl_lvl;
  logic         sda_lvl;
  logic         ack_seen;
  logic [7:0]   rx_byte;
  logic [15:0]  half_ticks;
  logic [15:0]  ack_limit;

  out_item_t    line_q[$];
  dir_row_t     dir_plan[$];
  int           mismatches;
  int           res_num;
  int           in_pace;
  int           out_pace;
  int           stall_left;
  int           idle_cycles;

  function automatic int unsigned clamp_cnt(int unsigned v);
    return (v > CNT_MAX) ? CNT_MAX : v;
  endfunction

  function automatic void go(bus_phase_t p, logic scl, logic sda);
    bus_phase = p;
    scl_lvl = scl;
    sda_lvl = sda;
    hold_count = 0;
  endfunction

  // One tick of the bus sequencer; returns the line levels and status after it
  function automatic out_item_t bus_step(in_item_t t);
    logic        done;
    int unsigned lim;
    out_item_t   r;
    done = 1'b0;
    lim = clamp_cnt((half_ticks == 16'd0) ? 1 : int'(half_ticks));
    if (bus_phase == PH_IDLE) begin
      case (t.func)
        FUNC_START: go(PH_ST_A, 1'b1, 1'b1);
        FUNC_STOP:  go(PH_SP_A, 1'b0, 1'b0);
        FUNC_WRITE: begin
          shift_reg = t.wdata;
          bit_cnt = 4'd0;
          go(PH_W_LOW, 1'b0, t.wdata[7]);
        end
        FUNC_READ: begin
          shift_reg = 8'h00;
          bit_cnt = 4'd0;
          go(PH_R_LOW, 1'b0, 1'b1);
        end
        default: ;
      endcase
    end else if (bus_phase > PH_N_HIGH) begin
      go(PH_IDLE, scl_lvl, sda_lvl);
    end else if (bus_phase == PH_A_WAIT) begin
      // SCL held high until the slave pulls SDA low or the wait runs out
      if (!t.sda_in) begin
        ack_seen = 1'b1;
        go(PH_A_END, 1'b0, 1'b1);
      end else begin
        if (hold_count < CNT_MAX) hold_count++;
        if (ack_limit != 16'd0 && hold_count >= clamp_cnt(ack_limit)) begin
          ack_seen = 1'b0;
          go(PH_A_END, 1'b0, 1'b1);
        end
      end
    end else begin
      if (hold_count < CNT_MAX) hold_count++;
      if (hold_count >= lim) begin
        case (bus_phase)
          PH_ST_A: go(PH_ST_B, 1'b1, 1'b0);
          PH_ST_B: begin
            go(PH_IDLE, 1'b0, 1'b0);
            done = 1'b1;
          end
          PH_SP_A: go(PH_SP_B, 1'b1, 1'b0);
          PH_SP_B: begin
            go(PH_IDLE, 1'b1, 1'b1);
            done = 1'b1;
          end
          PH_W_LOW: go(PH_W_HIGH, 1'b1, sda_lvl);
          PH_W_HIGH: begin
            shift_reg = shift_reg << 1;
            bit_cnt = bit_cnt + 4'd1;
            if (bit_cnt >= 4'd8) go(PH_A_LOW, 1'b0, 1'b1);
            else go(PH_W_LOW, 1'b0, shift_reg[7]);
          end
          PH_A_LOW: go(PH_A_WAIT, 1'b1, 1'b1);
          PH_A_END: begin
            go(PH_IDLE, 1'b0, 1'b1);
            done = 1'b1;
          end
          PH_R_LOW: go(PH_R_HIGH, 1'b1, 1'b1);
          // sample at the end of SCL high, MSB first
          PH_R_HIGH: begin
            shift_reg = {shift_reg[6:0], t.sda_in};
            bit_cnt = bit_cnt + 4'd1;
            if (bit_cnt >= 4'd8) go(PH_N_LOW, 1'b0, 1'b1);
            else go(PH_R_LOW, 1'b0, 1'b1);
          end
          PH_N_LOW: go(PH_N_HIGH, 1'b1, 1'b1);
          PH_N_HIGH: begin
            rx_byte = shift_reg;
            go(PH_IDLE, 1'b0, 1'b1);
            done = 1'b1;
          end
          default: go(PH_IDLE, scl_lvl, sda_lvl);
        endcase
      end
    end
    r.scl_out     = scl_lvl;
    r.sda_release = sda_lvl;
    r.busy_res    = (bus_phase != PH_IDLE);
    r.done_res    = done;
    r.rdata       = rx_byte;
    r.ack_ok      = ack_seen;
    return r;
  endfunction

  // Mostly whole commands with random content; some noise while busy
  function automatic in_item_t make_tick();
    in_item_t t;
    t.wdata = 8'($urandom_range(0, 255));
    t.sda_in = 1'($urandom_range(0, 1));
    t.func = FUNC_TICK;
    if (bus_phase == PH_IDLE) begin
      case ($urandom_range(0, 9))
        0: t.func = FUNC_TICK;
        1: t.func = 3'($urandom_range(FUNC_SPARE_LO, FUNC_SPARE_HI));
        2: t.func = FUNC_START;
        3: t.func = FUNC_STOP;
        4, 5, 6: t.func = FUNC_WRITE;
        default: t.func = FUNC_READ;
      endcase
    end else begin
      if ($urandom_range(0, 7) == 0) t.func = 3'($urandom_range(0, FUNC_SPARE_HI));
      // acknowledge comes late or not at all, so short timeouts do fire
      if (bus_phase == PH_A_WAIT) t.sda_in = ($urandom_range(0, 5) != 0);
    end
    return t;
  endfunction

  function automatic int draw_wait(int mode);
    case (mode)
      PACE_NONE: return 0;
      PACE_FULL: return $urandom_range(0, 15);
      default:   return ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : 0;
    endcase
  endfunction

  function automatic void add_row(logic [2:0] func, logic [7:0] wdata, logic sda,
                                  logic typed, out_item_t res);
    dir_row_t row;
    row.tick.func = func;
    row.tick.wdata = wdata;
    row.tick.sda_in = sda;
    row.typed = typed;
    row.res = res;
    dir_plan.push_back(row);
  endfunction

  task automatic report(string field, int got, int want);
    $display("mismatch result %0d %s: got 0x%0h want 0x%0h", res_num, field, got, want);
    mismatches++;
  endtask

  // Present one tick after a random gap and hold it until the transfer
  task automatic send_tick(in_item_t t, logic typed, out_item_t res);
    int        gap;
    out_item_t pred;
    gap = draw_wait(in_pace);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pred = bus_step(t);
    line_q.push_back(typed ? res : pred);
  endtask

  task automatic set_reg(logic idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_HALF_PERIOD) half_ticks = val;
    else ack_limit = val;
  endtask

  task automatic run_phase(logic [15:0] hp, logic [15:0] to, int n,
                           int in_mode, int out_mode);
    in_item_t t;
    while (line_q.size() != 0) @(posedge clk);
    set_reg(CFG_HALF_PERIOD, hp);
    set_reg(CFG_ACK_TIMEOUT, to);
    cfg_valid <= 1'b0;
    in_pace = in_mode;
    out_pace = out_mode;
    repeat (n) begin
      t = make_tick();
      send_tick(t, 1'b0, '0);
    end
    in_valid <= 1'b0;
  endtask

  // Result side back-pressure: a fresh stall length after every transfer
  always @(posedge clk) begin
    if (!rst_n) begin
      stall_left = 0;
    end else if (out_valid && !out_stall) begin
      stall_left = draw_wait(out_pace);
    end else if (stall_left > 0) begin
      stall_left--;
    end
    out_stall <= (stall_left > 0);
  end

  // Compare every result transfer with the oldest prediction
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (line_q.size() == 0) begin
        $display("unexpected result %0d: 0x%0h", res_num, out_data);
        mismatches++;
      end else begin
        want = line_q.pop_front();
        if (out_data.scl_out !== want.scl_out)
          report("scl_out", out_data.scl_out, want.scl_out);
        if (out_data.sda_release !== want.sda_release)
          report("sda_release", out_data.sda_release, want.sda_release);
        if (out_data.busy_res !== want.busy_res)
          report("busy_res", out_data.busy_res, want.busy_res);
        if (out_data.done_res !== want.done_res)
          report("done_res", out_data.done_res, want.done_res);
        if (out_data.rdata !== want.rdata)
          report("rdata", out_data.rdata, want.rdata);
        if (out_data.ack_ok !== want.ack_ok)
          report("ack_ok", out_data.ack_ok, want.ack_ok);
      end
      res_num++;
    end
  end

  // Watchdog: too long without any transfer on any channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", idle_cycles);
      $display("FAIL i2c_master_bit_engine");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_HALF_PERIOD;
    cfg_wdata = '0;
    in_pace = PACE_SPARSE;
    out_pace = PACE_SPARSE;

    // predictor reset state
    bus_phase = PH_IDLE;
    bit_cnt = 4'd0;
    shift_reg = 8'h00;
    hold_count = 0;
    scl_lvl = 1'b1;
    sda_lvl = 1'b1;
    ack_seen = 1'b0;
    rx_byte = 8'h00;
    half_ticks = HALF_PERIOD_RST;
    ack_limit = ACK_TIMEOUT_RST;

    // Directed part at reset config: idle, spare codes, start, busy commands
    add_row(FUNC_TICK,            8'h00, 1'b0, 1'b1, RES_IDLE_RESET);
    add_row(FUNC_SPARE_LO,        8'hFF, 1'b1, 1'b1, RES_IDLE_RESET);
    add_row(FUNC_SPARE_HI - 3'd1, 8'h5A, 1'b0, 1'b1, RES_IDLE_RESET);
    add_row(FUNC_SPARE_HI,        8'hA5, 1'b1, 1'b1, RES_IDLE_RESET);
    add_row(FUNC_START,           8'h00, 1'b1, 1'b1, RES_START_OPEN);
    // commands while busy are dropped
    add_row(FUNC_WRITE,           8'hFF, 1'b0, 1'b0, '0);
    add_row(FUNC_READ,            8'h00, 1'b1, 1'b0, '0);
    add_row(FUNC_STOP,            8'h81, 1'b0, 1'b0, '0);
    add_row(FUNC_START,           8'h7E, 1'b1, 1'b0, '0);
    for (int k = 0; k < 6; k++) add_row(FUNC_TICK, 8'(k), 1'(k), 1'b0, '0);
    add_row(FUNC_WRITE,           8'h80, 1'b1, 1'b1, RES_WRITE_MSB1);
    for (int k = 0; k < 8; k++) add_row(FUNC_TICK, 8'hF0, 1'(k + 1), 1'b0, '0);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_plan[k]) send_tick(dir_plan[k].tick, dir_plan[k].typed, dir_plan[k].res);
    in_valid <= 1'b0;

    // Random phases across settings, extremes included
    run_phase(16'd1,     16'd0,     180, PACE_NONE,   PACE_NONE);
    run_phase(16'd0,     16'd1,     150, PACE_FULL,   PACE_FULL);
    run_phase(16'd2,     16'd3,     170, PACE_SPARSE, PACE_FULL);
    run_phase(16'd3,     16'hFFFF,  160, PACE_FULL,   PACE_SPARSE);
    // slowest bus: only a short stretch, the command stays open
    run_phase(16'hFFFF,  16'd0,      40, PACE_SPARSE, PACE_SPARSE);
    run_phase(16'd1,     16'd2,     160, PACE_SPARSE, PACE_NONE);
    run_phase(16'd5,     16'd12,    160, PACE_NONE,   PACE_SPARSE);

    while (line_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS i2c_master_bit_engine");
    end else begin
      $display("FAIL i2c_master_bit_engine");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
hdl/i2cm_pkg.sv
hdl/i2cm_front.sv
hdl/i2cm_back.sv
hdl/i2c_master_bit_engine.sv
tb/tb.sv
